FILE: rtl/core/wpp_pkg.sv
package wpp_pkg;

  localparam int WINDOW_BYTES = 16;
  localparam int LEN_W        = 5;
  localparam int IDX_W        = (WINDOW_BYTES > 1) ? $clog2(WINDOW_BYTES) : 1;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 64;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] WILDCARD = 8'h3F;

  localparam logic [LEN_W-1:0] WINDOW_LEN = LEN_W'(WINDOW_BYTES);

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_HIGH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_LEN  = 3'd5;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } wpp_item_t;

  typedef struct packed {
    logic [WINDOW_BYTES-1:0][7:0] pattern;
    logic [WINDOW_BYTES-1:0][7:0] replace;
    logic [LEN_W-1:0]             match_len;
    logic [LEN_W-1:0]             patch_len;
  } wpp_cfg_t;

endpackage

FILE: rtl/core/wpp_front.sv
module wpp_front
  import wpp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic      in_last_i,
  output logic      q_valid_o,
  output wpp_item_t q_item_o,
  input  logic      q_pop_i
);

  wpp_item_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]    count_q;
  logic                 push, pop;

  assign in_stall_o = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (count_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{data: in_byte_i, last: in_last_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

FILE: rtl/core/wpp_back.sv
module wpp_back
  import wpp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  wpp_cfg_t   cfg_i,
  input  logic       q_valid_i,
  input  wpp_item_t  q_item_i,
  output logic       q_pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_replaced_o,
  output logic       out_last_o
);

  logic [WINDOW_BYTES-1:0][7:0] win_q, win_d, vwin, pwin;
  logic [WINDOW_BYTES-1:0]      rep_q, rep_d, vrep, prep;
  logic [LEN_W-1:0]             fill_q, fill_d, vfill;
  logic                         flush_q, flush_d, vflush;
  logic                         done_q, done_d;
  logic                         active_q, active_d;

  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_rep_q, out_last_q;

  logic out_room, take, emit, do_step, match, do_patch, emit_last;

  assign out_room = !out_valid_q || !out_stall_i;
  assign take     = !active_q && q_valid_i;

  always_comb begin
    vwin   = win_q;
    vrep   = rep_q;
    vfill  = fill_q;
    vflush = flush_q;
    if (take) begin
      vwin[fill_q[IDX_W-1:0]] = q_item_i.data;
      vrep[fill_q[IDX_W-1:0]] = 1'b0;
      vfill  = fill_q + 1'b1;
      vflush = q_item_i.last;
    end
  end

  // emit when a drain is pending, or the new byte is marked last or completes the window
  assign emit    = active_q || (take && (q_item_i.last || (vfill >= cfg_i.match_len)));
  assign do_step = (active_q || q_valid_i) && (!emit || out_room);
  assign q_pop_o = take && do_step;

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < WINDOW_BYTES; i++) begin
      if ((LEN_W'(i) < cfg_i.match_len) && (cfg_i.pattern[i] != WILDCARD) &&
          (cfg_i.pattern[i] != vwin[i])) begin
        match = 1'b0;
      end
    end
  end

  assign do_patch  = emit && !done_q && (vfill >= cfg_i.match_len) && match;
  assign emit_last = vflush && (vfill == LEN_W'(1));

  always_comb begin
    pwin = vwin;
    prep = vrep;
    for (int i = 0; i < WINDOW_BYTES; i++) begin
      if (do_patch && (LEN_W'(i) < cfg_i.patch_len) && (cfg_i.replace[i] != WILDCARD)) begin
        pwin[i] = cfg_i.replace[i];
        prep[i] = 1'b1;
      end
    end
  end

  always_comb begin
    win_d   = vwin;
    rep_d   = vrep;
    fill_d  = vfill;
    flush_d = vflush;
    done_d  = done_q;
    if (emit) begin
      win_d  = {8'h00, pwin[WINDOW_BYTES-1:1]};
      rep_d  = {1'b0, prep[WINDOW_BYTES-1:1]};
      fill_d = vfill - 1'b1;
      done_d = done_q || do_patch;
      if (emit_last) begin
        rep_d   = '0;
        fill_d  = '0;
        flush_d = 1'b0;
        done_d  = 1'b0;
      end
    end
    active_d = flush_d ? (fill_d != '0) : (fill_d >= cfg_i.match_len);
  end

  always_ff @(posedge clk_i) begin
    if (do_step) begin
      win_q <= win_d;
    end
    if (do_step && emit) begin
      out_byte_q <= pwin[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rep_q       <= '0;
      fill_q      <= '0;
      flush_q     <= 1'b0;
      done_q      <= 1'b0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_rep_q   <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      if (do_step) begin
        rep_q    <= rep_d;
        fill_q   <= fill_d;
        flush_q  <= flush_d;
        done_q   <= done_d;
        active_q <= active_d;
      end
      if (out_room) begin
        out_valid_q <= do_step && emit;
        if (do_step && emit) begin
          out_rep_q  <= prep[0];
          out_last_q <= emit_last;
        end
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign out_replaced_o = out_rep_q;
  assign out_last_o     = out_last_q;

endmodule

FILE: rtl/core/wildcard_pattern_patcher.sv
// Channel  Direction  Handshake            Payload
// in       input      in_valid_i/in_stall_o  in_byte_i, in_last_i
// out      output     out_valid_o/out_stall_i out_byte_o, out_replaced_o, out_last_o
// cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One byte per cycle in steady state while out_stall_i is low: the window
// compare is combinational over all positions and the drain emits one byte per cycle.
// A byte marked last drains the window, one held byte at a time (up to 16).
// Shortening the pattern length mid-stream drains the excess one byte a cycle while out_stall_i is low.
// The input queue holds 4 transactions; input stalls once it is full.
// Reset is asynchronous, active low; no clearing pass is needed.
module wildcard_pattern_patcher
  import wpp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            in_byte_i,
  input  logic                  in_last_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            out_byte_o,
  output logic                  out_replaced_o,
  output logic                  out_last_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [CFG_DATA_W-1:0] pat_lo_q, pat_hi_q, rep_lo_q, rep_hi_q;
  logic [LEN_W-1:0]      pat_len_q, rep_len_q;
  logic [LEN_W-1:0]      match_len;
  logic                  cfg_we;
  wpp_cfg_t              cfg;
  logic                  q_valid, q_pop;
  wpp_item_t             q_item;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q  <= '0;
      pat_hi_q  <= '0;
      pat_len_q <= LEN_W'(1);
      rep_lo_q  <= '0;
      rep_hi_q  <= '0;
      rep_len_q <= '0;
    end else if (cfg_we) begin
      case (cfg_index_i)
        CFG_PATTERN_LOW:  pat_lo_q  <= cfg_data_i;
        CFG_PATTERN_HIGH: pat_hi_q  <= cfg_data_i;
        CFG_PATTERN_LEN:  pat_len_q <= cfg_data_i[LEN_W-1:0];
        CFG_REPLACE_LOW:  rep_lo_q  <= cfg_data_i;
        CFG_REPLACE_HIGH: rep_hi_q  <= cfg_data_i;
        CFG_REPLACE_LEN:  rep_len_q <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp pattern length to 1..window, replacement length to the match length
  always_comb begin
    if (pat_len_q == '0) begin
      match_len = LEN_W'(1);
    end else if (pat_len_q > WINDOW_LEN) begin
      match_len = WINDOW_LEN;
    end else begin
      match_len = pat_len_q;
    end
  end

  always_comb begin
    for (int i = 0; i < WINDOW_BYTES; i++) begin
      if (i < 8) begin
        cfg.pattern[i] = pat_lo_q[8*(i%8) +: 8];
        cfg.replace[i] = rep_lo_q[8*(i%8) +: 8];
      end else begin
        cfg.pattern[i] = pat_hi_q[8*(i%8) +: 8];
        cfg.replace[i] = rep_hi_q[8*(i%8) +: 8];
      end
    end
    cfg.match_len = match_len;
    cfg.patch_len = (rep_len_q > match_len) ? match_len : rep_len_q;
  end

  wpp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  wpp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .q_valid_i      (q_valid),
    .q_item_i       (q_item),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .out_replaced_o (out_replaced_o),
    .out_last_o     (out_last_o)
  );

endmodule
